FILE: src/dbump_pkg.sv
`default_nettype none

package dbump_pkg;

    // Defaults for the top-level parameters
    localparam int unsigned NODE_BYTES_DEF = 16;
    localparam int unsigned MAX_POOL_DEF   = 65536;

    // Field widths
    localparam int unsigned CAP_W    = 17;
    localparam int unsigned LEN_W    = 16;
    localparam int unsigned HANDLE_W = 16;
    localparam int unsigned NODE_W   = 16;
    localparam int unsigned CNT_W    = 32;

    localparam logic [NODE_W-1:0]   NODE_LIMIT   = 16'hFFFE;
    localparam logic [CAP_W-1:0]    OFFSET_LIMIT = 17'h0FFFE;
    localparam logic [HANDLE_W-1:0] FAIL_HANDLE  = 16'hFFFF;

    typedef enum logic [1:0] {
        MODE_RESET  = 2'd0,
        MODE_NODE   = 2'd1,
        MODE_STRING = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    // One accepted command
    typedef struct packed {
        logic             valid;
        mode_t            mode;
        logic [LEN_W-1:0] len;
    } cmd_t;

    // One configuration write
    typedef struct packed {
        logic             valid;
        logic [CAP_W-1:0] data;
    } cfg_wr_t;

    // One result transaction
    typedef struct packed {
        logic                success;
        logic [HANDLE_W-1:0] handle;
        logic [NODE_W-1:0]   node_total;
        logic [CAP_W-1:0]    used_bytes;
        logic [CAP_W-1:0]    peak_bytes;
        logic [CNT_W-1:0]    alloc_total;
        logic [CNT_W-1:0]    reset_total;
    } result_t;

endpackage

`default_nettype wire

FILE: src/dbump_core.sv
`default_nettype none

module dbump_core #(
    parameter int unsigned NODE_BYTES     = dbump_pkg::NODE_BYTES_DEF,
    parameter int unsigned MAX_POOL_BYTES = dbump_pkg::MAX_POOL_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dbump_pkg::cmd_t    cmd,
    input  wire dbump_pkg::cfg_wr_t cfg,
    output dbump_pkg::result_t      res
);

    localparam int unsigned CW = dbump_pkg::CAP_W;
    localparam logic [CW:0]   NB_X    = (CW+1)'(NODE_BYTES);
    localparam logic [CW-1:0] MAX_CAP = CW'(MAX_POOL_BYTES);

    logic [CW-1:0]                 cap_reg, cap_next;
    logic [CW-1:0]                 cursor_reg, cursor_next;
    logic [CW-1:0]                 boundary_reg, boundary_next;
    logic [CW-1:0]                 used_reg, used_next;
    logic [CW-1:0]                 peak_reg, peak_next;
    logic [dbump_pkg::NODE_W-1:0]  node_reg, node_next;
    logic [dbump_pkg::CNT_W-1:0]   alloc_reg, alloc_next;
    logic [dbump_pkg::CNT_W-1:0]   resets_reg, resets_next;

    logic [CW-1:0] need;
    logic [CW:0]   str_diff;
    logic [CW:0]   node_end;
    logic [CW:0]   used_node;
    logic [CW:0]   used_str;
    logic          node_ok;
    logic          str_ok;
    logic          alloc_done;
    logic          success;
    logic [dbump_pkg::HANDLE_W-1:0] handle;
    logic [CW-1:0] cfg_cap;

    assign need      = {1'b0, cmd.len} + CW'(1);
    assign str_diff  = {1'b0, cursor_reg} - {1'b0, need};
    assign node_end  = {1'b0, boundary_reg} + NB_X;
    assign used_node = {1'b0, used_reg} + NB_X;
    assign used_str  = {1'b0, used_reg} + {1'b0, need};

    assign node_ok = (node_end <= {1'b0, cursor_reg}) && (node_reg < dbump_pkg::NODE_LIMIT);
    assign str_ok  = !str_diff[CW] && (str_diff[CW-1:0] >= boundary_reg)
                     && (str_diff[CW-1:0] <= dbump_pkg::OFFSET_LIMIT);

    assign cfg_cap = (cfg.data > MAX_CAP) ? MAX_CAP : cfg.data;

    always_comb
    begin
        cap_next      = cap_reg;
        cursor_next   = cursor_reg;
        boundary_next = boundary_reg;
        used_next     = used_reg;
        node_next     = node_reg;
        alloc_next    = alloc_reg;
        resets_next   = resets_reg;
        alloc_done    = 1'b0;
        success       = 1'b1;
        handle        = '0;

        if (cfg.valid)
        begin
            // zero capacity is ignored; anything else re-initializes the pool
            if (cfg.data != '0)
            begin
                cap_next      = cfg_cap;
                cursor_next   = cfg_cap;
                boundary_next = '0;
                used_next     = '0;
                node_next     = '0;
                alloc_next    = '0;
                resets_next   = dbump_pkg::CNT_W'(1);
            end
        end
        else if (cmd.valid)
        begin
            unique case (cmd.mode)
                dbump_pkg::MODE_RESET:
                begin
                    cursor_next   = cap_reg;
                    boundary_next = '0;
                    used_next     = '0;
                    node_next     = '0;
                    resets_next   = resets_reg + dbump_pkg::CNT_W'(1);
                end
                dbump_pkg::MODE_NODE:
                begin
                    if (node_ok)
                    begin
                        handle        = node_reg;
                        node_next     = node_reg + dbump_pkg::NODE_W'(1);
                        boundary_next = node_end[CW-1:0];
                        used_next     = used_node[CW-1:0];
                        alloc_next    = alloc_reg + dbump_pkg::CNT_W'(1);
                        alloc_done    = 1'b1;
                    end
                    else
                    begin
                        success = 1'b0;
                        handle  = dbump_pkg::FAIL_HANDLE;
                    end
                end
                dbump_pkg::MODE_STRING:
                begin
                    if (str_ok)
                    begin
                        cursor_next = str_diff[CW-1:0];
                        handle      = str_diff[dbump_pkg::HANDLE_W-1:0];
                        used_next   = used_str[CW-1:0];
                        alloc_next  = alloc_reg + dbump_pkg::CNT_W'(1);
                        alloc_done  = 1'b1;
                    end
                    else
                    begin
                        success = 1'b0;
                        handle  = dbump_pkg::FAIL_HANDLE;
                    end
                end
                dbump_pkg::MODE_QUERY:
                begin
                end
                default:
                begin
                end
            endcase
        end

        if (cfg.valid && cfg.data != '0)
            peak_next = '0;
        else if (alloc_done && used_next > peak_reg)
            peak_next = used_next;
        else
            peak_next = peak_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= MAX_CAP;
            cursor_reg   <= MAX_CAP;
            boundary_reg <= '0;
            used_reg     <= '0;
            peak_reg     <= '0;
            node_reg     <= '0;
            alloc_reg    <= '0;
            resets_reg   <= '0;
        end
        else
        begin
            cap_reg      <= cap_next;
            cursor_reg   <= cursor_next;
            boundary_reg <= boundary_next;
            used_reg     <= used_next;
            peak_reg     <= peak_next;
            node_reg     <= node_next;
            alloc_reg    <= alloc_next;
            resets_reg   <= resets_next;
        end
    end

    always_comb
    begin
        res.success     = success;
        res.handle      = handle;
        res.node_total  = node_next;
        res.used_bytes  = used_next;
        res.peak_bytes  = peak_next;
        res.alloc_total = alloc_next;
        res.reset_total = resets_next;
    end

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        (boundary_reg <= cursor_reg) && (cursor_reg <= cap_reg))
        else $error("node region crosses string region");

    a_used: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg == CW'({1'b0, boundary_reg} + {1'b0, cap_reg} - {1'b0, cursor_reg}))
        else $error("used byte count out of step with cursors");

    a_peak: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg >= used_reg)
        else $error("peak below current usage");

    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && !cfg.valid && !success |=> $stable(used_reg) && $stable(alloc_reg))
        else $error("failed allocation changed pool state");

endmodule

`default_nettype wire

FILE: src/double_ended_bump_allocator.sv
`default_nettype none

// Channel | Dir | Width | Contents
// s_*     | in  | 2+16  | s_tuser: mode; s_tdata: string_length
// m_*     | out | 1+136 | m_tuser: success; m_tdata: handle .. reset_total
// cfg_*   | in  | 17    | pool_capacity write, re-initializes the pool
//
// One command per cycle while s_tready is high: the command is accepted at an edge,
// the pool state updates at that same edge and the result lands in the output register
// there, so m_tvalid rises at that same edge.
// The output register holds a result under m_tready low; s_tready stays high
// whenever that register is empty or being drained and no cfg write is offered.
// Reset (rst_n low, asynchronous) sets a pool of MAX_POOL_BYTES bytes (65536 by
// default), clears all counters and empties the output register.

module double_ended_bump_allocator #(
    parameter int unsigned NODE_BYTES     = dbump_pkg::NODE_BYTES_DEF,
    parameter int unsigned MAX_POOL_BYTES = dbump_pkg::MAX_POOL_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,

    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [15:0] string_length
    input  wire logic [1:0]   s_tuser,   // [1:0] mode

    output logic              m_tvalid,
    input  wire logic         m_tready,
    // [15:0] handle, [31:16] node_total, [48:32] used_bytes,
    // [65:49] peak_bytes, [97:66] alloc_total, [129:98] reset_total, rest zero
    output logic [135:0]      m_tdata,
    output logic [0:0]        m_tuser,   // [0] success

    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [16:0]  cfg_data   // pool_capacity
);

    dbump_pkg::cmd_t    cmd;
    dbump_pkg::cfg_wr_t cfg;
    dbump_pkg::result_t res;
    dbump_pkg::result_t result_reg;
    logic               m_tvalid_reg;
    logic               s_fire;

    // Take a new command whenever the output register frees up this cycle;
    // hold commands off while a configuration write is offered
    assign s_tready  = (!m_tvalid_reg || m_tready) && !cfg_valid;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cmd.valid = s_fire;
        cmd.mode  = dbump_pkg::mode_t'(s_tuser);
        cmd.len   = s_tdata[dbump_pkg::LEN_W-1:0];
        cfg.valid = cfg_valid;
        cfg.data  = cfg_data;
    end

    dbump_core #(
        .NODE_BYTES     (NODE_BYTES),
        .MAX_POOL_BYTES (MAX_POOL_BYTES)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .cfg   (cfg),
        .res   (res)
    );

    // Output valid: set on a new command, drop once the result is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (s_fire)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    // Result payload: load on acceptance, hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_fire)
            result_reg <= res;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = result_reg.success;
    assign m_tdata  = {6'd0,
                       result_reg.reset_total,
                       result_reg.alloc_total,
                       result_reg.peak_bytes,
                       result_reg.used_bytes,
                       result_reg.node_total,
                       result_reg.handle};

    a_load: assert property (@(posedge clk) disable iff (!rst_n)
        s_fire |=> m_tvalid)
        else $error("accepted transaction produced no result");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transaction changed");

    a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_fire && cfg_valid))
        else $error("command accepted during a configuration write");

endmodule

`default_nettype wire

FILE: dv/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned REC_BYTES   = dbump_pkg::NODE_BYTES_DEF;
    localparam int unsigned POOL_MAX    = dbump_pkg::MAX_POOL_DEF;
    localparam int unsigned CYCLE_LIMIT = 400000;

    // Clock, reset and block ports
    logic         clk      = 1'b0;
    logic         rst_n    = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = '0;   // [15:0] string_length
    logic [1:0]   s_tuser  = '0;   // [1:0] mode
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [135:0] m_tdata;         // handle, node_total, used_bytes, peak_bytes,
                                   // alloc_total, reset_total (lowest first)
    logic [0:0]   m_tuser;         // [0] success
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [16:0]  cfg_data  = '0;  // pool_capacity

    double_ended_bump_allocator DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Pool bookkeeping as the block should see it; values after block reset
    int unsigned pool_cap   = POOL_MAX;
    int unsigned node_cnt   = 0;
    int unsigned str_cursor = POOL_MAX;
    int unsigned peak_seen  = 0;
    int unsigned allocs     = 0;
    int unsigned resets     = 0;

    dbump_pkg::result_t pending_results[$];
    int unsigned errors      = 0;
    int unsigned burst_left  = 0;
    int unsigned stall_left  = 0;
    int unsigned stall_style = 0;

    // Apply one command to the pool bookkeeping and return the result it yields.
    function automatic dbump_pkg::result_t pool_step(input dbump_pkg::mode_t mode,
                                                     input logic [15:0] len);
        dbump_pkg::result_t res;
        int unsigned need;
        int unsigned node_floor;
        int unsigned used;
        logic        grew;
        res.success = 1'b1;
        res.handle  = '0;
        grew        = 1'b0;
        case (mode)
            dbump_pkg::MODE_RESET:
            begin
                node_cnt   = 0;
                str_cursor = pool_cap;
                resets     = resets + 1;
            end
            dbump_pkg::MODE_NODE:
            begin
                // next node must end at or below the string cursor
                if ((node_cnt + 1) * REC_BYTES > str_cursor ||
                    node_cnt >= dbump_pkg::NODE_LIMIT)
                begin
                    res.success = 1'b0;
                    res.handle  = dbump_pkg::FAIL_HANDLE;
                end
                else
                begin
                    res.handle = node_cnt[15:0];
                    node_cnt   = node_cnt + 1;
                    allocs     = allocs + 1;
                    grew       = 1'b1;
                end
            end
            dbump_pkg::MODE_STRING:
            begin
                need       = int'(len) + 1;
                node_floor = node_cnt * REC_BYTES;
                // fail on underflow, collision with nodes, or an offset past 0xFFFE
                if (str_cursor < need || str_cursor - need < node_floor ||
                    str_cursor - need > dbump_pkg::OFFSET_LIMIT)
                begin
                    res.success = 1'b0;
                    res.handle  = dbump_pkg::FAIL_HANDLE;
                end
                else
                begin
                    str_cursor = str_cursor - need;
                    res.handle = str_cursor[15:0];
                    allocs     = allocs + 1;
                    grew       = 1'b1;
                end
            end
            default: ;
        endcase
        used = node_cnt * REC_BYTES + pool_cap - str_cursor;
        // peak moves only on a successful allocation
        if (grew && used > peak_seen)
            peak_seen = used;
        res.node_total  = node_cnt[15:0];
        res.used_bytes  = used[16:0];
        res.peak_bytes  = peak_seen[16:0];
        res.alloc_total = allocs;
        res.reset_total = resets;
        return res;
    endfunction

    // Send one command; hold valid through bursts, drop it during gaps.
    task automatic send_cmd(input dbump_pkg::mode_t mode, input logic [15:0] len);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // occasional long burst gives stretches with no idling
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= len;
        s_tuser  <= mode;
        do
            @(posedge clk);
        while (!s_tready);
        // transaction accepted at this edge
        pending_results.push_back(pool_step(mode, len));
        burst_left = burst_left - 1;
    endtask

    // Stop sending and hold until every expected result has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // Write pool_capacity; call only with the block idle.
    task automatic write_capacity(input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        // a zero write is dropped, oversize saturates, anything else re-initializes
        if (value != 0)
        begin
            pool_cap   = (int'(value) > POOL_MAX) ? POOL_MAX : int'(value);
            node_cnt   = 0;
            str_cursor = pool_cap;
            peak_seen  = 0;
            allocs     = 0;
            resets     = 1;
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        errors = errors + 1;
    endtask

    // Check each result transaction and drive the receiver stall pattern.
    always @(posedge clk)
    begin : result_monitor
        dbump_pkg::result_t got;
        dbump_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.success     = m_tuser[0];
            got.handle      = m_tdata[15:0];
            got.node_total  = m_tdata[31:16];
            got.used_bytes  = m_tdata[48:32];
            got.peak_bytes  = m_tdata[65:49];
            got.alloc_total = m_tdata[97:66];
            got.reset_total = m_tdata[129:98];
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual 0x%0h", $time, got);
                errors = errors + 1;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.success !== want.success)
                    report_mismatch("success", 32'(want.success), 32'(got.success));
                if (got.handle !== want.handle)
                    report_mismatch("handle", 32'(want.handle), 32'(got.handle));
                if (got.node_total !== want.node_total)
                    report_mismatch("node_total", 32'(want.node_total),
                                    32'(got.node_total));
                if (got.used_bytes !== want.used_bytes)
                    report_mismatch("used_bytes", 32'(want.used_bytes),
                                    32'(got.used_bytes));
                if (got.peak_bytes !== want.peak_bytes)
                    report_mismatch("peak_bytes", 32'(want.peak_bytes),
                                    32'(got.peak_bytes));
                if (got.alloc_total !== want.alloc_total)
                    report_mismatch("alloc_total", want.alloc_total, got.alloc_total);
                if (got.reset_total !== want.reset_total)
                    report_mismatch("reset_total", want.reset_total, got.reset_total);
            end
        end
        // pick a new stall style every so often: open, light, heavy, or solid stall
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(8, 80);
        end
        stall_left = stall_left - 1;
        case (stall_style)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= ($urandom_range(0, 3) == 0);
            default: m_tready <= 1'b0;
        endcase
    end

    // Default 64 KiB pool: boundary cases before any capacity write.
    task automatic test_default_pool();
        send_cmd(dbump_pkg::MODE_QUERY, 16'd0);
        send_cmd(dbump_pkg::MODE_STRING, 16'd0);       // offset would be 0xFFFF: refuse
        send_cmd(dbump_pkg::MODE_NODE, 16'hFFFF);      // length ignored outside string mode
        send_cmd(dbump_pkg::MODE_STRING, 16'hFFFF);    // would overlap the first node
        send_cmd(dbump_pkg::MODE_STRING, 16'd65519);   // lands exactly on the node boundary
        send_cmd(dbump_pkg::MODE_NODE, 16'd0);         // no room left
        send_cmd(dbump_pkg::MODE_STRING, 16'd0);       // no room left
        send_cmd(dbump_pkg::MODE_RESET, 16'h5A5A);
        send_cmd(dbump_pkg::MODE_QUERY, 16'hFFFF);
    endtask

    // Capacity extremes: smallest pool, saturation, one-node pool, ignored zero.
    task automatic test_capacity_writes();
        drain();
        write_capacity(17'd1);
        send_cmd(dbump_pkg::MODE_NODE, 16'd0);         // node larger than the pool
        send_cmd(dbump_pkg::MODE_STRING, 16'd0);       // terminator alone fills it
        send_cmd(dbump_pkg::MODE_STRING, 16'd0);       // cursor already at zero
        send_cmd(dbump_pkg::MODE_QUERY, 16'd0);
        drain();
        write_capacity(17'h1FFFF);                     // saturates to the maximum
        send_cmd(dbump_pkg::MODE_NODE, 16'd0);
        send_cmd(dbump_pkg::MODE_STRING, 16'd0);
        drain();
        write_capacity(17'd16);
        send_cmd(dbump_pkg::MODE_NODE, 16'd0);         // exactly one node fits
        send_cmd(dbump_pkg::MODE_NODE, 16'd0);
        send_cmd(dbump_pkg::MODE_STRING, 16'd0);
        send_cmd(dbump_pkg::MODE_RESET, 16'd0);
        send_cmd(dbump_pkg::MODE_STRING, 16'd15);      // string fills the whole pool
        drain();
        write_capacity(17'd0);                         // dropped: state carries on
        send_cmd(dbump_pkg::MODE_QUERY, 16'd0);
    endtask

    // Random command mix over a series of pool sizes.
    task automatic test_random_traffic();
        logic [16:0]      cap;
        int unsigned      span;
        int unsigned      pick;
        logic [15:0]      len;
        dbump_pkg::mode_t mode;
        for (int phase = 0; phase < 10; phase++)
        begin
            case (phase)
                0:       cap = 17'd64;
                1:       cap = 17'd1;
                2:       cap = 17'd65536;
                3:       cap = 17'h1FFFF;
                4:       cap = 17'd0;
                9:       cap = 17'($urandom_range(1, 131071));
                default: cap = 17'($urandom_range(1, 2048));
            endcase
            drain();
            write_capacity(cap);
            span = pool_cap / 6;
            if (span < 4)
                span = 4;
            for (int n = 0; n < 65; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    mode = dbump_pkg::MODE_RESET;
                else if (pick < 42)
                    mode = dbump_pkg::MODE_NODE;
                else if (pick < 82)
                    mode = dbump_pkg::MODE_STRING;
                else
                    mode = dbump_pkg::MODE_QUERY;
                // mostly lengths on the scale of the pool, some across the full field
                if ($urandom_range(0, 3) == 0)
                    len = 16'($urandom_range(0, 65535));
                else
                    len = 16'($urandom_range(0, (span > 65535) ? 65535 : span));
                send_cmd(mode, len);
            end
        end
    endtask

    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_pool();
        test_capacity_writes();
        test_random_traffic();
        drain();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/dbump_pkg.sv
src/dbump_core.sv
src/double_ended_bump_allocator.sv
dv/tb.sv
